FILE: design/lfe_pkg.sv
// Shared constants for the LED fire effect block.
`timescale 1ns / 1ps
`default_nettype none

package lfe_pkg;

  localparam int DEFAULT_MAX_CELLS = 256;

  localparam int CNT_W   = 9;
  localparam int RATE_W  = 8;
  localparam int RND_W   = 16;
  localparam int HEAT_W  = 8;
  localparam int COLOR_W = 8;
  localparam int SCELL_W = 3;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 9;
  localparam int SPAN_W  = 12;
  localparam int DSTEP_W = 4;

  localparam logic [CNT_W-1:0]  RST_CELL_COUNT   = 9'd60;
  localparam logic [RATE_W-1:0] RST_COOLING_RATE = 8'd55;
  localparam logic [RATE_W-1:0] RST_SPARK_CHANCE = 8'd120;

  localparam logic [CIDX_W-1:0] REG_CELL_COUNT   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COOLING_RATE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SPARK_CHANCE = 2'd2;

  localparam logic [DSTEP_W-1:0] DIV_LAST_STEP = 4'd15;
  localparam logic [3:0]         COOL_MULT     = 4'd10;
  localparam logic [1:0]         SPAN_BIAS     = 2'd2;

  // x / 3 as (x * 683) >> 11, exact for x < 768
  localparam logic [9:0]  THIRD_MULT  = 10'd683;
  localparam int          THIRD_SHIFT = 11;
  // t = (h * 191 + 127) / 255; the divide is (y * 32897) >> 23, exact for y < 48833
  localparam logic [7:0]  HEAT_SCALE  = 8'd191;
  localparam logic [6:0]  HEAT_ROUND  = 7'd127;
  localparam logic [15:0] INV255_MULT = 16'd32897;
  localparam int          INV255_SHIFT = 23;

  localparam logic [7:0] BAND_HIGH = 8'h80;
  localparam logic [7:0] BAND_MID  = 8'h40;
  localparam logic [7:0] FULL      = 8'hFF;

endpackage

`default_nettype wire

FILE: design/lfe_ifs.sv
// Channel interfaces of the LED fire effect block: input, result and config write.
`timescale 1ns / 1ps
`default_nettype none

interface lfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [lfe_pkg::RND_W-1:0]     cool_random;
  logic [lfe_pkg::RATE_W-1:0]    spark_roll;
  logic [lfe_pkg::SCELL_W-1:0]   spark_cell;
  logic [lfe_pkg::HEAT_W-1:0]    spark_add;

  modport source (output valid, cool_random, spark_roll, spark_cell, spark_add,
                  input ready);
  modport sink (input valid, cool_random, spark_roll, spark_cell, spark_add,
                output ready);
endinterface

interface lfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [lfe_pkg::COLOR_W-1:0]   red;
  logic [lfe_pkg::COLOR_W-1:0]   green;
  logic [lfe_pkg::COLOR_W-1:0]   blue;
  logic                          frame_last;

  modport source (output valid, red, green, blue, frame_last, input ready);
  modport sink (input valid, red, green, blue, frame_last, output ready);
endinterface

interface lfe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lfe_pkg::CIDX_W-1:0]    index;
  logic [lfe_pkg::CDAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/led_fire_effect.sv
// Top level of the LED fire effect: heat memory, shared divider and color mapping.
//
//  channel  | dir | payload                                   | handshake
//  in_ch    | in  | cool_random, spark_roll, spark_cell, add  | valid/ready
//  out_ch   | out | red, green, blue, frame_last              | valid/ready
//  cfg_ch   | in  | index, data                               | valid/ready
//
// Each item passes through accept plus heat read, 16 steps of the bit-serial
// divider for the cooldown modulo, then heat update, scale and color stages.
// After reset a clearing pass writes zero to every heat memory entry; then, and after
// each write to the cell count or cooling rate, the input is held off while the
// cooldown span is divided out.
// A waiting result sits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module led_fire_effect #(
  parameter int MAX_CELLS = lfe_pkg::DEFAULT_MAX_CELLS
) (
  input  wire       clk,
  input  wire       rst_n,
  lfe_in_if.sink    in_ch,
  lfe_out_if.source out_ch,
  lfe_cfg_if.sink   cfg_ch
);

  localparam int AW  = $clog2(MAX_CELLS);
  localparam int NW  = AW + 1;
  localparam int CMW = (NW > lfe_pkg::CNT_W) ? NW : lfe_pkg::CNT_W;
  localparam int DW  = (NW > lfe_pkg::SPAN_W) ? NW : lfe_pkg::SPAN_W;
  localparam int RW  = lfe_pkg::RND_W;
  localparam int HW  = lfe_pkg::HEAT_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SPAN  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_COLOR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [HW-1:0] heat_mem [MAX_CELLS];
  logic [HW-1:0] rd_heat_r;

  logic [lfe_pkg::CNT_W-1:0]  cell_count_r;
  logic [lfe_pkg::RATE_W-1:0] cooling_rate_r;
  logic [lfe_pkg::RATE_W-1:0] spark_chance_r;
  logic                       dirty_r;
  logic [lfe_pkg::SPAN_W-1:0] span_r;

  logic [AW-1:0]  clr_r;
  logic [AW-1:0]  pos_r;
  logic [HW-1:0]  cp_r, cp2_r;

  logic [RW-1:0]               quo_r;
  logic [DW-1:0]               rem_r;
  logic [DW-1:0]               dvs_r;
  logic [lfe_pkg::DSTEP_W-1:0] step_r;

  logic [lfe_pkg::RATE_W-1:0]  roll_r;
  logic [lfe_pkg::SCELL_W-1:0] scell_r;
  logic [HW-1:0]               sadd_r;

  logic [HW-1:0] heat_r;
  logic          last_r;
  logic [15:0]   y_r;

  logic                         out_valid_r;
  logic [lfe_pkg::COLOR_W-1:0]  red_r, green_r, blue_r;
  logic                         frame_last_r;

  // effective cell count
  logic [CMW-1:0] cc_ext, n_c;
  logic [NW-1:0]  eff_n;

  // divider step
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW-1:0] rem_nxt;
  logic [RW-1:0] quo_nxt;

  // heat update
  logic [HW-1:0] cooled;
  logic [9:0]    diff_sum;
  logic [19:0]   third_prod;
  logic [HW-1:0] third;
  logic [HW-1:0] base_heat;
  logic          spark_hit;
  logic [HW-1:0] new_heat;
  logic [NW-1:0] pos_inc;
  logic          is_last;

  // color
  logic [31:0] t_prod;
  logic [7:0]  t_val;
  logic [7:0]  ramp;
  logic [7:0]  red_c, green_c, blue_c;

  logic in_acc, cfg_acc, out_load;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign in_ch.ready  = (state_r == S_IDLE) && !dirty_r;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;
  assign out_ch.frame_last = frame_last_r;

  always_comb begin
    cc_ext = CMW'(cell_count_r);
    if (cc_ext == '0) begin
      n_c = CMW'(1);
    end else if (cc_ext > CMW'(MAX_CELLS)) begin
      n_c = CMW'(MAX_CELLS);
    end else begin
      n_c = cc_ext;
    end
    eff_n = n_c[NW-1:0];
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[RW-1]};
    rem_ge  = rem_sh >= {1'b0, dvs_r};
    rem_nxt = rem_ge ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
    quo_nxt = {quo_r[RW-2:0], rem_ge};
  end

  always_comb begin
    cooled     = (rem_r > DW'(rd_heat_r)) ? '0 : HW'(rd_heat_r - rem_r[HW-1:0]);
    diff_sum   = 10'(cp_r) + {1'b0, cp2_r, 1'b0};
    third_prod = diff_sum * lfe_pkg::THIRD_MULT;
    third      = third_prod[lfe_pkg::THIRD_SHIFT +: HW];
    base_heat  = (pos_r >= AW'(2)) ? third : cooled;
    spark_hit  = (roll_r < spark_chance_r) && (AW'(scell_r) == pos_r);
    new_heat   = spark_hit ? HW'(base_heat + sadd_r) : base_heat;
    pos_inc    = NW'(pos_r) + NW'(1);
    is_last    = pos_inc >= eff_n;
  end

  always_comb begin
    t_prod = y_r * lfe_pkg::INV255_MULT;
    t_val  = t_prod[lfe_pkg::INV255_SHIFT +: 8];
    ramp   = {t_val[5:0], 2'b00};
    if (t_val > lfe_pkg::BAND_HIGH) begin
      red_c = lfe_pkg::FULL; green_c = lfe_pkg::FULL; blue_c = ramp;
    end else if (t_val > lfe_pkg::BAND_MID) begin
      red_c = lfe_pkg::FULL; green_c = ramp; blue_c = '0;
    end else begin
      red_c = ramp; green_c = '0; blue_c = '0;
    end
  end

  assign out_load = (state_r == S_COLOR) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(MAX_CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (dirty_r) begin
          state_nxt = S_SPAN;
        end else if (in_acc) begin
          state_nxt = S_MOD;
        end
      end
      S_SPAN:  if (step_r == lfe_pkg::DIV_LAST_STEP) state_nxt = S_IDLE;
      S_MOD:   if (step_r == lfe_pkg::DIV_LAST_STEP) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_COLOR;
      S_COLOR: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // heat memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      heat_mem[clr_r] <= '0;
    end else if (state_r == S_CALC) begin
      heat_mem[pos_r] <= new_heat;
    end
    if (in_acc) begin
      rd_heat_r <= heat_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      pos_r          <= '0;
      cp_r           <= '0;
      cp2_r          <= '0;
      dirty_r        <= 1'b1;
      cell_count_r   <= lfe_pkg::RST_CELL_COUNT;
      cooling_rate_r <= lfe_pkg::RST_COOLING_RATE;
      spark_chance_r <= lfe_pkg::RST_SPARK_CHANCE;
      out_valid_r    <= 1'b0;
      step_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end

      if (state_r == S_IDLE && dirty_r) begin
        dirty_r <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_ch.index)
          lfe_pkg::REG_CELL_COUNT: begin
            cell_count_r <= cfg_ch.data;
            dirty_r      <= 1'b1;
          end
          lfe_pkg::REG_COOLING_RATE: begin
            cooling_rate_r <= cfg_ch.data[lfe_pkg::RATE_W-1:0];
            dirty_r        <= 1'b1;
          end
          lfe_pkg::REG_SPARK_CHANCE: begin
            spark_chance_r <= cfg_ch.data[lfe_pkg::RATE_W-1:0];
          end
          default: ;
        endcase
      end

      if (state_r == S_SPAN || state_r == S_MOD) begin
        step_r <= step_r + lfe_pkg::DSTEP_W'(1);
      end else begin
        step_r <= '0;
      end

      if (state_r == S_CALC) begin
        cp2_r <= cp_r;
        cp_r  <= cooled;
        pos_r <= is_last ? '0 : pos_inc[AW-1:0];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && dirty_r) begin
      quo_r <= RW'(cooling_rate_r) * RW'(lfe_pkg::COOL_MULT);
      rem_r <= '0;
      dvs_r <= DW'(eff_n);
    end else if (in_acc) begin
      quo_r   <= in_ch.cool_random;
      rem_r   <= '0;
      dvs_r   <= DW'(span_r);
      roll_r  <= in_ch.spark_roll;
      scell_r <= in_ch.spark_cell;
      sadd_r  <= in_ch.spark_add;
    end else if (state_r == S_SPAN || state_r == S_MOD) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end

    if (state_r == S_SPAN && step_r == lfe_pkg::DIV_LAST_STEP) begin
      span_r <= quo_nxt[lfe_pkg::SPAN_W-1:0] + lfe_pkg::SPAN_W'(lfe_pkg::SPAN_BIAS);
    end

    if (state_r == S_CALC) begin
      heat_r <= new_heat;
      last_r <= is_last;
    end

    if (state_r == S_SCALE) begin
      y_r <= 16'(heat_r) * 16'(lfe_pkg::HEAT_SCALE) + 16'(lfe_pkg::HEAT_ROUND);
    end

    if (out_load) begin
      red_r        <= red_c;
      green_r      <= green_c;
      blue_r       <= blue_c;
      frame_last_r <= last_r;
    end
  end

endmodule

`default_nettype wire

FILE: dv/led_fire_effect_test.sv
// Self-checking testbench for the LED fire effect block, with a heat-map predictor.
`timescale 1ns / 1ps

module led_fire_effect_test;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned STRIP_MAX   = 256;
  localparam logic [lfe_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [lfe_pkg::RND_W-1:0]   cool_random;
    logic [lfe_pkg::RATE_W-1:0]  spark_roll;
    logic [lfe_pkg::SCELL_W-1:0] spark_cell;
    logic [lfe_pkg::HEAT_W-1:0]  spark_add;
  } fire_cell_t;

  typedef struct packed {
    logic [lfe_pkg::COLOR_W-1:0] red;
    logic [lfe_pkg::COLOR_W-1:0] green;
    logic [lfe_pkg::COLOR_W-1:0] blue;
    logic                        frame_last;
  } pixel_t;

  class fire_scoreboard;
    logic [lfe_pkg::HEAT_W-1:0] heat_map [STRIP_MAX];
    int unsigned position, cooled_prev, cooled_prev2;
    logic [lfe_pkg::CNT_W-1:0]  cell_count;
    logic [lfe_pkg::RATE_W-1:0] cooling_rate;
    logic [lfe_pkg::RATE_W-1:0] spark_chance;
    pixel_t pending_pixels[$];
    int unsigned errors, cells_seen, frames_seen, sparks_seen;
    int unsigned band_hits[3];

    function new();
      foreach (heat_map[i]) heat_map[i] = '0;
      position = 0;
      cooled_prev = 0;
      cooled_prev2 = 0;
      cell_count = lfe_pkg::RST_CELL_COUNT;
      cooling_rate = lfe_pkg::RST_COOLING_RATE;
      spark_chance = lfe_pkg::RST_SPARK_CHANCE;
    endfunction

    function void report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void set_reg(logic [lfe_pkg::CIDX_W-1:0] idx,
                          logic [lfe_pkg::CDAT_W-1:0] value);
      case (idx)
        lfe_pkg::REG_CELL_COUNT:   cell_count = value;
        lfe_pkg::REG_COOLING_RATE: cooling_rate = value[lfe_pkg::RATE_W-1:0];
        lfe_pkg::REG_SPARK_CHANCE: spark_chance = value[lfe_pkg::RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_cell(fire_cell_t c);
      int unsigned n, k, span, cool, cooled, h, t, ramp;
      pixel_t p;
      n = (cell_count == 0) ? 1 : ((cell_count > STRIP_MAX) ? STRIP_MAX : cell_count);
      k = (position >= STRIP_MAX) ? STRIP_MAX - 1 : position;
      span = (cooling_rate * lfe_pkg::COOL_MULT) / n + lfe_pkg::SPAN_BIAS;
      cool = c.cool_random % span;
      h = heat_map[k];
      cooled = (cool > h) ? 0 : h - cool;
      if (k >= 2) h = (cooled_prev + 2 * cooled_prev2) / 3;
      else h = cooled;
      if (c.spark_roll < spark_chance && c.spark_cell == k) begin
        h = (h + c.spark_add) & 8'hFF;
        sparks_seen++;
      end
      heat_map[k] = h[lfe_pkg::HEAT_W-1:0];
      cooled_prev2 = cooled_prev;
      cooled_prev = cooled;
      t = (h * lfe_pkg::HEAT_SCALE + lfe_pkg::HEAT_ROUND) / 255;
      ramp = (t & 8'h3F) << 2;
      if (t > lfe_pkg::BAND_HIGH) begin
        p.red = lfe_pkg::FULL; p.green = lfe_pkg::FULL; p.blue = ramp[7:0];
        band_hits[2]++;
      end else if (t > lfe_pkg::BAND_MID) begin
        p.red = lfe_pkg::FULL; p.green = ramp[7:0]; p.blue = '0;
        band_hits[1]++;
      end else begin
        p.red = ramp[7:0]; p.green = '0; p.blue = '0;
        band_hits[0]++;
      end
      p.frame_last = (k + 1 >= n);
      position = p.frame_last ? 0 : k + 1;
      if (p.frame_last) frames_seen++;
      cells_seen++;
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                         got.red, got.green, got.blue, got.frame_last));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.red !== want.red)
        report($sformatf("red %0d, want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green %0d, want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue %0d, want %0d", got.blue, want.blue));
      if (got.frame_last !== want.frame_last)
        report($sformatf("frame_last %0b, want %0b", got.frame_last, want.frame_last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  int unsigned hold_req = 0;
  int unsigned sink_wait = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  fire_scoreboard sb;

  lfe_in_if  in_ch ();
  lfe_out_if out_ch ();
  lfe_cfg_if cfg_ch ();

  led_fire_effect dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, calm stretches, and requested long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cycles % 150 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      if (hold_req != 0) begin
        sink_wait = hold_req;
        hold_req = 0;
      end
      if (sink_wait != 0) begin
        out_ch.ready <= 1'b0;
        sink_wait--;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        sink_wait = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_cell('{in_ch.cool_random, in_ch.spark_roll, in_ch.spark_cell,
                       in_ch.spark_add});
      if (out_ch.valid && out_ch.ready)
        sb.check_pixel('{out_ch.red, out_ch.green, out_ch.blue, out_ch.frame_last});
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  task automatic write_setting(input logic [lfe_pkg::CIDX_W-1:0] idx,
                               input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[lfe_pkg::CDAT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_strip(input int unsigned cells, input int unsigned cooling,
                           input int unsigned chance);
    write_setting(lfe_pkg::REG_CELL_COUNT, cells);
    write_setting(lfe_pkg::REG_COOLING_RATE, cooling);
    write_setting(lfe_pkg::REG_SPARK_CHANCE, chance);
  endtask

  task automatic send_cell(input fire_cell_t c);
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.cool_random <= c.cool_random;
    in_ch.spark_roll  <= c.spark_roll;
    in_ch.spark_cell  <= c.spark_cell;
    in_ch.spark_add   <= c.spark_add;
    do @(posedge clk); while (!in_ch.ready);
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic fire_cell_t new_frame_sparks();
    fire_cell_t f;
    f.cool_random = '0;
    f.spark_roll  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 254);
    f.spark_cell  = $urandom_range(0, 7);
    f.spark_add   = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(160, 254);
    return f;
  endfunction

  function automatic fire_cell_t make_cell(input fire_cell_t frame);
    fire_cell_t c;
    int unsigned r;
    c = ($urandom_range(0, 9) == 0) ? new_frame_sparks() : frame;
    r = $urandom_range(0, 9);
    if (r < 5) c.cool_random = $urandom_range(0, 65535);
    else if (r < 8) c.cool_random = $urandom_range(0, 31);
    else c.cool_random = $urandom_range(0, 3000);
    return c;
  endfunction

  task automatic run_frames(input int unsigned frame_len, input int unsigned count,
                            input bit calm, input int unsigned hold);
    fire_cell_t frame;
    src_calm = calm;
    if (hold != 0) hold_req = hold;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % frame_len == 0) frame = new_frame_sparks();
      send_cell(make_cell(frame));
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cool_random = '0;
    in_ch.spark_roll = '0;
    in_ch.spark_cell = '0;
    in_ch.spark_add = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, extremes of the raw random and the roll
    src_calm = 1'b1;
    send_cell('{16'h0000, 8'd0, 3'd0, 8'hFF});
    send_cell('{16'hFFFF, 8'd255, 3'd1, 8'h00});
    send_cell('{16'h5555, 8'd119, 3'd2, 8'd160});
    drain();

    // zero count acts as one; position already past it ends the frame
    write_setting(lfe_pkg::REG_CELL_COUNT, 0);
    send_cell('{16'h0001, 8'd0, 3'd0, 8'd160});
    send_cell('{16'h0000, 8'd0, 3'd0, 8'd254});
    drain();

    // five cells, cooling rate zero, sparks always; first frame sparks beyond the strip
    set_strip(5, 0, 255);
    write_setting(REG_UNUSED, 9'h1FF);
    for (int i = 0; i < 5; i++) send_cell('{16'hAAAA, 8'd254, 3'd6, 8'd200});
    send_cell('{16'hFFFF, 8'd254, 3'd4, 8'd254});
    send_cell('{16'h0000, 8'd0, 3'd3, 8'd160});
    send_cell('{16'h8000, 8'd1, 3'd2, 8'd255});
    send_cell('{16'h7FFF, 8'd128, 3'd1, 8'd127});
    send_cell('{16'h0000, 8'd64, 3'd0, 8'd200});
    drain();

    // strongest cooling over five cells
    write_setting(lfe_pkg::REG_COOLING_RATE, 255);
    send_cell('{16'hFFFF, 8'd255, 3'd7, 8'd255});
    send_cell('{16'h01FF, 8'd0, 3'd1, 8'd160});
    send_cell('{16'h0200, 8'd0, 3'd2, 8'd254});
    send_cell('{16'h0000, 8'd0, 3'd3, 8'd200});
    send_cell('{16'h1234, 8'd0, 3'd4, 8'd180});
    drain();

    set_strip(8, 0, 255);
    run_frames(8, 64, 1'b0, 0);

    set_strip(511, 255, 0);
    run_frames(256, 60, 1'b0, 0);

    // long result hold-off while the sender keeps offering
    set_strip(256, 0, 255);
    run_frames(256, 80, 1'b1, 400);

    set_strip(1, 255, 200);
    run_frames(1, 30, 1'b0, 0);

    for (int r = 0; r < 3; r++) begin
      int unsigned cells;
      cells = $urandom_range(3, 20);
      set_strip(cells, $urandom_range(0, 255), $urandom_range(0, 255));
      run_frames(cells, 40, r == 1, 0);
    end

    set_strip(60, 55, 120);
    run_frames(60, 40, 1'b0, 0);
    run_frames(60, 40, 1'b0, 0);

    repeat (60) @(posedge clk);
    $display("%0d cells over %0d frames, %0d sparks; dark/orange/white bands hit %0d/%0d/%0d",
             sb.cells_seen, sb.frames_seen, sb.sparks_seen,
             sb.band_hits[0], sb.band_hits[1], sb.band_hits[2]);
    $display("%0d mismatches, %0d pixels still owed", sb.errors, sb.pending_pixels.size());
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lfe_pkg.sv
design/lfe_ifs.sv
design/led_fire_effect.sv
dv/led_fire_effect_test.sv
